// ----- hw/rtl/cbi_pkg.sv -----
// ----------------------------------------------------------------------------
// cbi_pkg
// Shared constants and types for the convolutional byte interleaver: branch
// count, unit delay, delay memory layout and the request that goes from the
// commutator stage to the delay memory stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cbi_pkg;

  // interleaver geometry
  localparam int BRANCHES    = 52;
  localparam int UNIT_DELAY  = 4;
  localparam int BYTE_W      = 8;

  // branch b (b >= 1) owns the first b*UNIT_DELAY entries of its stride;
  // branch 0 has no storage, so the memory starts at branch 1
  localparam int RING_STRIDE = (BRANCHES - 1) * UNIT_DELAY;
  localparam int STORE_DEPTH = (BRANCHES - 1) * RING_STRIDE;

  localparam int BRANCH_W    = $clog2(BRANCHES);
  localparam int POS_W       = $clog2(RING_STRIDE + 1);
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // output queue, depth must be a power of two
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_IDX_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 3);

  // delay memory access for one transaction
  typedef struct packed {
    logic              valid;
    logic              pass;
    logic              filled;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } delay_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cbi_branch_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbi_branch_ctrl
// Commutator and per-branch ring pointers. Holds the branch select, the ring
// pointer memory and the touched and filled flags, and builds the delay
// memory request for each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cbi_branch_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_take,
  input  wire logic [cbi_pkg::BYTE_W-1:0] data_in,
  input  wire logic                       restart,
  output cbi_pkg::delay_req_t             req
);

  logic [cbi_pkg::BRANCH_W-1:0] branch_select;
  logic [cbi_pkg::BRANCH_W-1:0] branch_cur;
  logic [cbi_pkg::BRANCH_W-1:0] branch_next;
  logic [cbi_pkg::BRANCH_W-1:0] branch_dec;

  logic                         s1_valid;
  logic [cbi_pkg::BRANCH_W-1:0] s1_branch;
  logic [cbi_pkg::BYTE_W-1:0]   s1_data;

  logic [cbi_pkg::POS_W-1:0]    ptr_mem [cbi_pkg::BRANCHES];
  logic [cbi_pkg::POS_W-1:0]    ptr_rdata;
  logic [cbi_pkg::BRANCHES-1:0] touched;
  logic [cbi_pkg::BRANCHES-1:0] filled;

  logic [cbi_pkg::POS_W-1:0]    ring_len;
  logic [cbi_pkg::POS_W-1:0]    pos_raw;
  logic [cbi_pkg::POS_W-1:0]    pos;
  logic [cbi_pkg::POS_W-1:0]    pos_inc;
  logic [cbi_pkg::POS_W-1:0]    pos_next;
  logic                         wrap;
  logic                         is_pass;
  logic                         ptr_we;
  logic [cbi_pkg::ADDR_W-1:0]   ring_base;

  // commutator: restart forces branch 0 for this transaction
  always_comb begin
    branch_cur  = restart ? '0 : branch_select;
    branch_next = (branch_cur == cbi_pkg::BRANCH_W'(cbi_pkg::BRANCHES - 1)) ?
                  '0 : branch_cur + 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      branch_select <= '0;
      s1_valid      <= 1'b0;
    end else begin
      s1_valid <= in_take;
      if (in_take) begin
        branch_select <= branch_next;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_branch <= branch_cur;
      s1_data   <= data_in;
    end
  end

  // ring pointer memory: read on accept, write back in the following cycle;
  // consecutive transactions never hit the same nonzero branch
  always_ff @(posedge clk) begin
    if (in_take) begin
      ptr_rdata <= ptr_mem[branch_cur];
    end
    if (ptr_we) begin
      ptr_mem[s1_branch] <= pos_next;
    end
  end

  // touched: pointer entry written since reset; filled: ring wrapped once
  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
      filled  <= '0;
    end else if (ptr_we) begin
      touched[s1_branch] <= 1'b1;
      if (wrap) begin
        filled[s1_branch] <= 1'b1;
      end
    end
  end

  // pointer update and address
  always_comb begin
    is_pass    = (s1_branch == '0);
    ptr_we     = s1_valid && !is_pass;
    ring_len   = cbi_pkg::POS_W'(s1_branch * cbi_pkg::UNIT_DELAY);
    pos_raw    = touched[s1_branch] ? ptr_rdata : '0;
    pos        = (pos_raw >= ring_len) ? '0 : pos_raw;
    pos_inc    = pos + 1'b1;
    wrap       = (pos_inc >= ring_len);
    pos_next   = wrap ? '0 : pos_inc;
    branch_dec = s1_branch - 1'b1;
    ring_base  = cbi_pkg::ADDR_W'(branch_dec * cbi_pkg::RING_STRIDE);
  end

  // request to the delay memory
  always_comb begin
    req.valid  = s1_valid;
    req.pass   = is_pass;
    req.filled = filled[s1_branch];
    req.addr   = ring_base + cbi_pkg::ADDR_W'(pos);
    req.data   = s1_data;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cbi_delay_mem.sv -----
// ----------------------------------------------------------------------------
// cbi_delay_mem
// Delay memory of all branch rings. Reads the oldest byte and writes the new
// byte at the same entry in the same cycle, then picks the output byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cbi_delay_mem (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  cbi_pkg::delay_req_t             req,
  output logic                            byte_valid,
  output logic [cbi_pkg::BYTE_W-1:0]      byte_out
);

  logic [cbi_pkg::BYTE_W-1:0] store [cbi_pkg::STORE_DEPTH];
  logic [cbi_pkg::BYTE_W-1:0] rdata;

  logic                       s2_valid;
  logic                       s2_pass;
  logic                       s2_filled;
  logic [cbi_pkg::BYTE_W-1:0] s2_data;

  // read-first access: old byte out, new byte in
  always_ff @(posedge clk) begin
    if (req.valid && !req.pass) begin
      rdata            <= store[req.addr];
      store[req.addr]  <= req.data;
    end
  end

  // stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= req.valid;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (req.valid) begin
      s2_pass   <= req.pass;
      s2_filled <= req.filled;
      s2_data   <= req.data;
    end
  end

  // branch 0 passes through; an unfilled ring gives zeros, not its stored bytes
  always_comb begin
    byte_valid = s2_valid;
    if (s2_pass) begin
      byte_out = s2_data;
    end else if (s2_filled) begin
      byte_out = rdata;
    end else begin
      byte_out = '0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cbi_out_fifo.sv -----
// ----------------------------------------------------------------------------
// cbi_out_fifo
// Small output queue that decouples the pipeline from output stall. Input
// stall is raised from register state when the queue plus the bytes still
// in the pipeline could fill it.
// ----------------------------------------------------------------------------
`default_nettype none

module cbi_out_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [cbi_pkg::BYTE_W-1:0] push_data,
  input  wire logic [1:0]                 inflight,
  output logic                            full_soon,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [cbi_pkg::BYTE_W-1:0]      data_out
);

  logic [cbi_pkg::BYTE_W-1:0]     fifo_mem [cbi_pkg::FIFO_DEPTH];
  logic [cbi_pkg::FIFO_IDX_W-1:0] wr_idx;
  logic [cbi_pkg::FIFO_IDX_W-1:0] rd_idx;
  logic [cbi_pkg::FIFO_CNT_W-1:0] count;
  logic                           pop;

  // handshake
  always_comb begin
    out_valid = (count != '0);
    pop       = out_valid && !out_stall;
    data_out  = fifo_mem[rd_idx];
    full_soon = (count + cbi_pkg::FIFO_CNT_W'(inflight)) >=
                cbi_pkg::FIFO_CNT_W'(cbi_pkg::FIFO_DEPTH);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= wr_idx + 1'b1;
      end
      if (pop) begin
        rd_idx <= rd_idx + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_idx] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/convolutional_byte_interleaver.sv -----
// ----------------------------------------------------------------------------
// convolutional_byte_interleaver
// Forney convolutional byte interleaver, 52 branches, unit delay of 4 bytes.
// ----------------------------------------------------------------------------
// Takes one byte per transaction and gives one interleaved byte per
// transaction, sustaining one byte every clock cycle while in_stall is low,
// with no clearing pass after reset. An accepted byte goes through the read
// of the branch ring pointer memory, the read-and-write access to the delay
// memory and the write into the output queue, in that order. Each branch
// ring costs one delay memory access per byte, which sets the rate at one
// byte per cycle while in_stall is low. Rings that have not yet wrapped give
// zeros, as after a reset of the delay memory. restart puts the commutator
// on branch 0 for its own byte; ring contents and pointers are kept.
// in_stall rises only when the four-entry output queue is close to full.
// ----------------------------------------------------------------------------
`default_nettype none

module convolutional_byte_interleaver (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [cbi_pkg::BYTE_W-1:0] data_in,
  input  wire logic                       restart,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [cbi_pkg::BYTE_W-1:0]      data_out
);

  cbi_pkg::delay_req_t        req;
  logic                       in_take;
  logic                       byte_valid;
  logic [cbi_pkg::BYTE_W-1:0] byte_out;
  logic [1:0]                 inflight;
  logic                       full_soon;

  // input handshake
  always_comb begin
    in_stall = full_soon;
    in_take  = in_valid && !full_soon;
    inflight = {1'b0, req.valid} + {1'b0, byte_valid};
  end

  // commutator and ring pointers
  cbi_branch_ctrl u_branch_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_take (in_take),
    .data_in (data_in),
    .restart (restart),
    .req     (req)
  );

  // delay memory
  cbi_delay_mem u_delay_mem (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .byte_valid (byte_valid),
    .byte_out   (byte_out)
  );

  // output queue
  cbi_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (byte_valid),
    .push_data (byte_out),
    .inflight  (inflight),
    .full_soon (full_soon),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out)
  );

endmodule

`default_nettype wire
